### rtl/apq_pkg.sv
// Shared types and codes for the array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package apq_pkg;

  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int HELD_W = 5;
  localparam int STAT_W = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

endpackage
`default_nettype wire

### rtl/apq_ram.sv
// Generic one-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module apq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/apq_best.sv
// Shared comparator that tracks the highest-priority entry seen in a scan.
`timescale 1ns / 1ps
`default_nettype none
module apq_best #(
  parameter int IDX_W = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic               cand_valid,
  input  wire logic [IDX_W-1:0]   cand_idx,
  input  wire apq_pkg::entry_t    cand,
  output logic      [IDX_W-1:0]   best_idx,
  output apq_pkg::entry_t         best
);
  import apq_pkg::*;

  logic             have_r;
  logic             have_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  entry_t           best_r;
  entry_t           best_nxt;
  logic             take;

  // Strict greater keeps the earliest entry on ties.
  assign take = cand_valid && (!have_r || (cand.pri > best_r.pri));

  always_comb begin
    have_nxt = have_r;
    idx_nxt  = idx_r;
    best_nxt = best_r;
    if (clear) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt = 1'b1;
      idx_nxt  = cand_idx;
      best_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
  end

  assign best_idx = idx_r;
  assign best     = best_r;

endmodule
`default_nettype wire

### rtl/array_priority_queue_unit.sv
// Top level of the array priority queue: sequencer, job store and scan comparator.
//
// Usage: one input beat carries an operation (enqueue or dequeue) with a job id and
// priority; each input beat yields exactly one result beat with status, the taken
// job (zero unless a dequeue succeeds) and the count of jobs held afterwards.
// Jobs sit unsorted in a RAM; a dequeue scans every stored entry through one shared
// comparator, reading one entry per cycle, then closes the gap by moving each later
// entry down one place, one read and one write per cycle.
// Enqueue, overflow and underflow go from acceptance straight to the result state; a
// dequeue first runs the scan, pick and shift states, whose length grows with the job
// count and the winner's distance from the tail, bound by the single RAM read port. At most one item is in
// flight: in_stall is high from acceptance until the result is loaded into the
// output register. A result waiting under out_stall does not block the next input
// beat; only the following result waits until the output register drains.
// Reset (synchronous, rst_n low) empties the queue and drops any pending result;
// the RAM keeps no reset and needs no clearing pass, since only entries below the
// job count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module array_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_operation,
  input  wire logic [apq_pkg::ID_W-1:0]     in_job_id,
  input  wire logic [apq_pkg::PRI_W-1:0]    in_job_priority,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [apq_pkg::STAT_W-1:0]   out_status,
  output logic      [apq_pkg::ID_W-1:0]     out_taken_id,
  output logic      [apq_pkg::PRI_W-1:0]    out_taken_priority,
  output logic      [apq_pkg::HELD_W-1:0]   out_jobs_held
);
  import apq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SCAN      = 7'b0000010,
    ST_SCAN_END  = 7'b0000100,
    ST_PICK      = 7'b0001000,
    ST_SHIFT     = 7'b0010000,
    ST_SHIFT_END = 7'b0100000,
    ST_RESULT    = 7'b1000000
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [IDX_W-1:0]    iss_r;
  logic [IDX_W-1:0]    iss_nxt;
  logic                pend_r;
  logic                pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    rd_idx_nxt;

  logic [STAT_W-1:0]   res_status_r;
  logic [STAT_W-1:0]   res_status_nxt;
  entry_t              res_job_r;
  entry_t              res_job_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r;
  logic [STAT_W-1:0]   out_status_nxt;
  entry_t              out_job_r;
  entry_t              out_job_nxt;
  logic [HELD_W-1:0]   out_held_r;
  logic [HELD_W-1:0]   out_held_nxt;

  // Store port controls.
  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  entry_t              ram_wr_data;
  logic                ram_rd_en;
  entry_t              ram_rd_data;

  // Comparator controls.
  logic                best_clear;
  logic                cand_valid;
  logic [IDX_W-1:0]    best_idx;
  entry_t              best_job;

  logic [IDX_W-1:0]    last_idx;
  entry_t              in_job;

  // Index of the youngest stored job; meaningful only while the queue is not empty.
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign in_job   = '{id: in_job_id, pri: in_job_priority};

  // Feed each returned read to the comparator while scanning.
  assign cand_valid = pend_r && ((state_r == ST_SCAN) || (state_r == ST_SCAN_END));

  apq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (iss_r),
    .rd_data (ram_rd_data)
  );

  apq_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (best_clear),
    .cand_valid (cand_valid),
    .cand_idx   (rd_idx_r),
    .cand       (ram_rd_data),
    .best_idx   (best_idx),
    .best       (best_job)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    res_status_nxt = res_status_r;
    res_job_nxt    = res_job_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_job_nxt    = out_job_r;
    out_held_nxt   = out_held_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = IDX_W'(count_r);
    ram_wr_data    = in_job;
    ram_rd_en      = 1'b0;
    best_clear     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_job_nxt = '0;
          state_nxt   = ST_RESULT;
          if (in_operation == OP_ENQUEUE) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_status_nxt = STATUS_OVERFLOW;
            end else begin
              // Append at the tail.
              res_status_nxt = STATUS_OK;
              ram_wr_en      = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            res_status_nxt = STATUS_UNDERFLOW;
          end else begin
            best_clear = 1'b1;
            iss_nxt    = '0;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the comparator sees the data once the RAM has registered it.
        ram_rd_en  = 1'b1;
        pend_nxt   = 1'b1;
        rd_idx_nxt = iss_r;
        if (iss_r == last_idx) begin
          state_nxt = ST_SCAN_END;
        end else begin
          iss_nxt = iss_r + IDX_W'(1);
        end
      end

      ST_SCAN_END: begin
        // Last candidate settles into the comparator at this edge.
        state_nxt = ST_PICK;
      end

      ST_PICK: begin
        if (best_idx == last_idx) begin
          state_nxt = ST_SHIFT_END;
        end else begin
          iss_nxt   = best_idx + IDX_W'(1);
          state_nxt = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // Read entry k+1 while writing entry k, read last cycle, down to k-1.
        ram_rd_en  = 1'b1;
        pend_nxt   = 1'b1;
        rd_idx_nxt = iss_r;
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_idx_r - IDX_W'(1);
          ram_wr_data = ram_rd_data;
        end
        if (iss_r == last_idx) begin
          state_nxt = ST_SHIFT_END;
        end else begin
          iss_nxt = iss_r + IDX_W'(1);
        end
      end

      ST_SHIFT_END: begin
        // Drain the last move, drop the taken job from the count.
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_idx_r - IDX_W'(1);
          ram_wr_data = ram_rd_data;
        end
        count_nxt      = count_r - CNT_W'(1);
        res_status_nxt = STATUS_OK;
        res_job_nxt    = best_job;
        state_nxt      = ST_RESULT;
      end

      ST_RESULT: begin
        // Hold until the output register is free, then hand the result over.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_job_nxt    = res_job_r;
          out_held_nxt   = HELD_W'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_status_r <= res_status_nxt;
    res_job_r    <= res_job_nxt;
    out_status_r <= out_status_nxt;
    out_job_r    <= out_job_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_taken_id       = out_job_r.id;
  assign out_taken_priority = out_job_r.pri;
  assign out_jobs_held      = out_held_r;

endmodule
`default_nettype wire

### tb/sv/array_priority_queue_unit_test.sv
// Self-checking testbench for the array priority queue: directed table, then random job traffic.
`timescale 1ns / 1ps
module array_priority_queue_unit_test;
  import apq_pkg::*;

  localparam int DEPTH         = 16;      // jobs the store holds
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_BEATS  = 1800;
  localparam int SEGMENTS      = 8;       // random part split into idling phases
  localparam int SETTLE_CYCLES = 60;      // longer than the slowest dequeue
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_CAP    = 100;

  // One result beat as the block presents it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   taken_id;
    logic [PRI_W-1:0]  taken_pri;
    logic [HELD_W-1:0] held;
  } outcome_t;

  // One directed input beat; want is used only where typed is set.
  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             typed;
    outcome_t         want;
  } stim_row_t;

  localparam outcome_t NO_WANT = '0;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_ENQUEUE;
  logic [ID_W-1:0]     in_job_id = '0;
  logic [PRI_W-1:0]    in_job_priority = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_taken_id;
  logic [PRI_W-1:0]    out_taken_priority;
  logic [HELD_W-1:0]   out_jobs_held;

  // Job store as the predictor sees it: unsorted, oldest at index 0.
  logic [ID_W-1:0]  held_ids  [DEPTH];
  logic [PRI_W-1:0] held_pris [DEPTH];
  int               jobs_stored = 0;

  outcome_t outcomes_due[$];   // results owed by the block, oldest first

  // Typed expectation that travels with the beat on the input ports.
  logic     row_typed = 1'b0;
  outcome_t row_want  = NO_WANT;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int n_enqueued     = 0;
  int n_dequeued     = 0;
  int n_overflows    = 0;
  int n_underflows   = 0;
  int peak_held      = 0;
  int cycle_count    = 0;

  // Directed beats: empty, single job, ties, fill to full, overflow, dequeue from full.
  // Dequeue rows carry junk id and priority, which the block must ignore.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_DEQUEUE, 16'hFFFF, 8'hFF, 1'b1, '{STATUS_UNDERFLOW, 16'h0000, 8'h00, 5'd0}},
    '{OP_ENQUEUE, 16'hFFFF, 8'hFF, 1'b1, '{STATUS_OK, 16'h0000, 8'h00, 5'd1}},
    '{OP_DEQUEUE, 16'h0000, 8'h00, 1'b1, '{STATUS_OK, 16'hFFFF, 8'hFF, 5'd0}},
    '{OP_ENQUEUE, 16'h0000, 8'h00, 1'b1, '{STATUS_OK, 16'h0000, 8'h00, 5'd1}},
    '{OP_ENQUEUE, 16'h1234, 8'h00, 1'b1, '{STATUS_OK, 16'h0000, 8'h00, 5'd2}},
    '{OP_DEQUEUE, 16'hABCD, 8'h5A, 1'b1, '{STATUS_OK, 16'h0000, 8'h00, 5'd1}},
    '{OP_DEQUEUE, 16'h0000, 8'h00, 1'b1, '{STATUS_OK, 16'h1234, 8'h00, 5'd0}},
    '{OP_ENQUEUE, 16'h8000, 8'h80, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h0001, 8'h01, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hC003, 8'hFF, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h7FFF, 8'h7F, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h5555, 8'hFF, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hAAAA, 8'h00, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h0F0F, 8'h55, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hF0F0, 8'hAA, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h00FF, 8'hFE, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hFF00, 8'h80, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h3C3C, 8'h33, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hC3C3, 8'hCC, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h1111, 8'hFF, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hEEEE, 8'h0F, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'h2468, 8'hF0, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hFFFE, 8'h80, 1'b0, NO_WANT},
    '{OP_ENQUEUE, 16'hDEAD, 8'hEE, 1'b1, '{STATUS_OVERFLOW, 16'h0000, 8'h00, 5'd16}},
    '{OP_DEQUEUE, 16'h5A5A, 8'hA5, 1'b0, NO_WANT}
  };

  array_priority_queue_unit #(.CAPACITY(DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_job_id          (in_job_id),
    .in_job_priority    (in_job_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_taken_id       (out_taken_id),
    .out_taken_priority (out_taken_priority),
    .out_jobs_held      (out_jobs_held)
  );

  always #1 clk = ~clk;

  // Apply one job operation to the predicted store and return the result it owes.
  function automatic outcome_t serve_job_op(input logic op, input logic [ID_W-1:0] id,
                                            input logic [PRI_W-1:0] pri);
    outcome_t r;
    int       best;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_ENQUEUE) begin
      n_enqueued++;
      if (jobs_stored >= DEPTH) begin
        r.status = STATUS_OVERFLOW;
        n_overflows++;
      end else begin
        held_ids[jobs_stored]  = id;
        held_pris[jobs_stored] = pri;
        jobs_stored++;
      end
    end else begin
      n_dequeued++;
      if (jobs_stored == 0) begin
        r.status = STATUS_UNDERFLOW;
        n_underflows++;
      end else begin
        // Strictly greater only, so the earliest job wins a tie.
        best = 0;
        for (int k = 1; k < jobs_stored; k++)
          if (held_pris[k] > held_pris[best]) best = k;
        r.taken_id  = held_ids[best];
        r.taken_pri = held_pris[best];
        for (int k = best; k + 1 < jobs_stored; k++) begin
          held_ids[k]  = held_ids[k + 1];
          held_pris[k] = held_pris[k + 1];
        end
        jobs_stored--;
      end
    end
    r.held = HELD_W'(jobs_stored);
    if (jobs_stored > peak_held) peak_held = jobs_stored;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Sample both channels at the rising edge. Check the result beat first: it can never
  // belong to an input beat accepted on the same edge.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t predicted;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result beat, expected none, actual %0d/0x%0h/0x%0h/%0d",
                     $time, out_status, out_taken_id, out_taken_priority, out_jobs_held);
        end else begin
          want = outcomes_due.pop_front();
          results_seen++;
          compare_field("status", ID_W'(want.status), ID_W'(out_status));
          compare_field("taken_id", want.taken_id, out_taken_id);
          compare_field("taken_priority", ID_W'(want.taken_pri), ID_W'(out_taken_priority));
          compare_field("jobs_held", ID_W'(want.held), ID_W'(out_jobs_held));
        end
      end
      if (in_valid && !in_stall) begin
        // Always advance the predicted store, even where the row types its own result.
        predicted = serve_job_op(in_operation, in_job_id, in_job_priority);
        outcomes_due.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  // Stall the result channel at random, as the current phase asks.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, outcomes_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one input beat. Enter and leave at a falling edge; idle cycles put junk on
  // the payload with valid low, and the payload holds while the block stalls it.
  task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri, input logic typed,
                           input outcome_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid        = 1'b0;
      in_operation    = 1'($urandom_range(1));
      in_job_id       = ID_W'($urandom);
      in_job_priority = PRI_W'($urandom);
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_operation    = op;
    in_job_id       = id;
    in_job_priority = pri;
    row_typed       = typed;
    row_want        = want;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_drained();
    in_valid  = 1'b0;
    row_typed = 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  // Random traffic in bursts: each burst picks how often it enqueues (drain, balanced,
  // fill up to overflow) and how priorities spread (full range, heavy ties, extremes).
  task automatic send_random_segment(input int beats);
    int               burst_left;
    int               enq_pct;
    int               pri_mode;
    logic             op;
    logic [PRI_W-1:0] pri;
    burst_left = 0;
    enq_pct    = 50;
    pri_mode   = 0;
    repeat (beats) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
        pri_mode = $urandom_range(2);
      end
      burst_left--;
      op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      case (pri_mode)
        0:       pri = PRI_W'($urandom_range(255));
        1:       pri = PRI_W'($urandom_range(3));
        default: pri = $urandom_range(1) ? 8'hFF : PRI_W'($urandom_range(1));
      endcase
      send_beat(op, ID_W'($urandom_range(65535)), pri, 1'b0, NO_WANT);
    end
  endtask

  initial begin
    // Hold reset low, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table with both sides running flat out.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_beat(directed_rows[i].op, directed_rows[i].id, directed_rows[i].pri,
                directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // Cycle through the idling phases; drain fully between segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      send_random_segment(RANDOM_BEATS / SEGMENTS);
      wait_drained();
    end

    // Let any stray result beat show up before closing.
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d results: %0d enqueues (%0d refused as full), %0d dequeues (%0d on empty)",
             results_seen, n_enqueued, n_overflows, n_dequeued, n_underflows);
    $display("Store peaked at %0d of %0d jobs; %0d mismatches", peak_held, DEPTH, mismatches);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
